// ===== hw/rtl/pcm_pkg.sv =====
// Shared types and constants of the palette color modulator.
package pcm_pkg;

	localparam int SECTION_ENTRIES = 256;
	localparam int ROW_ENTRIES     = 16;
	localparam int ROW_SHIFT       = $clog2(ROW_ENTRIES);
	localparam int BANK_COUNT      = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE         = 3'd0,
		REG_RED_BIAS     = 3'd1,
		REG_GREEN_BIAS   = 3'd2,
		REG_BLUE_BIAS    = 3'd3,
		REG_FULL_SECTION = 3'd4,
		REG_ROW_SELECT   = 3'd5,
		REG_BANK_SELECT  = 3'd6,
		REG_KEEP_RESULT  = 3'd7
	} reg_idx_t;

	localparam logic [2:0] MODE_HALVE  = 3'd5;
	localparam logic [2:0] MODE_GRAY6  = 3'd6;
	localparam logic [2:0] MODE_GRAY12 = 3'd7;

	typedef struct packed {
		logic [2:0]        mode;
		logic signed [6:0] red_bias;
		logic signed [6:0] green_bias;
		logic signed [6:0] blue_bias;
		logic              full_section;
		logic [3:0]        row_select;
		logic [3:0]        bank_select;
		logic              keep_result;
	} cfg_t;

	typedef struct packed {
		logic [7:0] entry;
		logic       last;
	} dest_t;

endpackage

// ===== hw/rtl/pcm_regs.sv =====
// Configuration register file of the palette color modulator.
module pcm_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pcm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pcm_pkg::cfg_t                    cfg
);

	pcm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (pcm_pkg::reg_idx_t'(cfg_index))
				pcm_pkg::REG_MODE:         cfg_q.mode         <= cfg_data[2:0];
				pcm_pkg::REG_RED_BIAS:     cfg_q.red_bias     <= $signed(cfg_data);
				pcm_pkg::REG_GREEN_BIAS:   cfg_q.green_bias   <= $signed(cfg_data);
				pcm_pkg::REG_BLUE_BIAS:    cfg_q.blue_bias    <= $signed(cfg_data);
				pcm_pkg::REG_FULL_SECTION: cfg_q.full_section <= cfg_data[0];
				pcm_pkg::REG_ROW_SELECT:   cfg_q.row_select   <= cfg_data[3:0];
				pcm_pkg::REG_BANK_SELECT:  cfg_q.bank_select  <= cfg_data[3:0];
				pcm_pkg::REG_KEEP_RESULT:  cfg_q.keep_result  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/pcm_position.sv =====
// Destination position counter: entry index and last-entry flag.
module pcm_position #(
	parameter int SECTION_ENTRIES = pcm_pkg::SECTION_ENTRIES,
	localparam int PosW = $clog2(SECTION_ENTRIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  pcm_pkg::cfg_t       cfg,
	output pcm_pkg::dest_t      dest,
	output logic [PosW-1:0]     position
);

	localparam logic [PosW:0] SectionLim = (PosW+1)'(SECTION_ENTRIES);
	localparam logic [PosW:0] RowLim     = (PosW+1)'(pcm_pkg::ROW_ENTRIES);

	logic [PosW-1:0] position_q;
	logic [PosW:0]   pos_inc;
	logic [PosW:0]   limit;
	logic            last;
	logic [7:0]      row_base;

	assign pos_inc  = {1'b0, position_q} + (PosW+1)'(1);
	assign limit    = cfg.full_section ? SectionLim : RowLim;
	assign last     = (pos_inc >= limit);
	assign row_base = 8'(8'(cfg.row_select) << pcm_pkg::ROW_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (advance) begin
			position_q <= last ? '0 : pos_inc[PosW-1:0];
		end
	end

	always_comb begin
		dest.last  = last;
		dest.entry = cfg.full_section ? 8'(position_q) : 8'(row_base + 8'(position_q));
	end

	assign position = position_q;

endmodule

// ===== hw/rtl/pcm_modulate.sv =====
// Color modulation datapath: halve, gray or direct bias add, then clamp.
module pcm_modulate (
	input  logic [15:0]    color,
	input  pcm_pkg::cfg_t  cfg,
	output logic [15:0]    result
);

	function automatic logic [4:0] clamp5(input logic signed [7:0] v);
		logic [4:0] c;
		if (v >= 8'sd32)
			c = 5'd31;
		else if (v <= 8'sd0)
			c = 5'd0;
		else
			c = v[4:0];
		return c;
	endfunction

	logic [4:0]         r, g, b;
	logic [7:0]         sum;
	logic [6:0]         div_in;
	logic [14:0]        prod;
	logic [4:0]         gray;
	logic [4:0]         base_r, base_g, base_b;
	logic signed [7:0]  add_r, add_g, add_b;
	logic [4:0]         cr, cg, cb, cb_fix;

	assign r = color[4:0];
	assign g = color[9:5];
	assign b = color[14:10];

	// sum / 6 = (sum >> 1) / 3, sum / 12 = (sum >> 2) / 3; x / 3 = (x * 171) >> 9
	assign sum    = 8'({r, 1'b0}) + 8'(8'(g) * 8'd3) + 8'(b);
	assign div_in = (cfg.mode == pcm_pkg::MODE_GRAY6) ? sum[7:1] : 7'(sum[7:2]);
	assign prod   = 15'(div_in) * 15'd171;
	assign gray   = prod[13:9];

	always_comb begin
		unique case (cfg.mode)
			pcm_pkg::MODE_HALVE: begin
				base_r = 5'(r[4:1]);
				base_g = 5'(g[4:1]);
				base_b = 5'(b[4:1]);
			end
			pcm_pkg::MODE_GRAY6, pcm_pkg::MODE_GRAY12: begin
				base_r = gray;
				base_g = gray;
				base_b = gray;
			end
			default: begin
				base_r = r;
				base_g = g;
				base_b = b;
			end
		endcase
	end

	assign add_r = $signed({3'b000, base_r}) + 8'(cfg.red_bias);
	assign add_g = $signed({3'b000, base_g}) + 8'(cfg.green_bias);
	assign add_b = $signed({3'b000, base_b}) + 8'(cfg.blue_bias);

	assign cr = clamp5(add_r);
	assign cg = clamp5(add_g);
	assign cb = clamp5(add_b);

	// nonzero color must not turn black
	assign cb_fix = ((cr | cg | cb) == 5'd0 && color[14:0] != 15'd0) ? 5'd1 : cb;

	assign result = (color == 16'd0) ? 16'd0 : {color[15], cb_fix, cg, cr};

endmodule

// ===== hw/rtl/palette_color_modulator_top.sv =====
// Top level of the palette color modulator: config, position, two-stage pipeline.
// Throughput is one transaction per cycle while out_stall is low, set by the input
// register and the result register around the single-pass modulation logic, with
// the position counter stepping at input accept. in_stall only rises when both
// stages hold data and out_stall is high. The user must see that configuration is
// written only while no transaction is in flight; the block does not enforce it.
module palette_color_modulator_top #(
	parameter int SECTION_ENTRIES = pcm_pkg::SECTION_ENTRIES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [15:0]                     source_color,
	input  logic                            row_animated,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [3:0]                      bank,
	output logic [7:0]                      entry_index,
	output logic [15:0]                     packed_result,
	output logic                            write_modified,
	output logic                            write_components,
	output logic                            last_entry
);

	localparam int PosW = $clog2(SECTION_ENTRIES);

	pcm_pkg::cfg_t   cfg;
	pcm_pkg::dest_t  dest;
	logic [PosW-1:0] position;

	logic            in_accept;
	logic            load_s2;
	logic            valid_s1;
	logic [15:0]     color_s1;
	logic            animated_s1;
	pcm_pkg::dest_t  dest_s1;
	logic [15:0]     result;

	logic            valid_s2;
	logic [3:0]      bank_s2;
	logic [7:0]      entry_s2;
	logic [15:0]     packed_s2;
	logic            wmod_s2;
	logic            wcomp_s2;
	logic            last_s2;

	pcm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcm_position #(
		.SECTION_ENTRIES (SECTION_ENTRIES)
	) u_position (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (in_accept),
		.cfg      (cfg),
		.dest     (dest),
		.position (position)
	);

	pcm_modulate u_modulate (
		.color  (color_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign load_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (load_s2)
				valid_s1 <= 1'b0;
			if (load_s2)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			color_s1    <= source_color;
			animated_s1 <= row_animated;
			dest_s1     <= dest;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			bank_s2   <= 4'({3'b000, cfg.bank_select} % 7'(pcm_pkg::BANK_COUNT));
			entry_s2  <= dest_s1.entry;
			packed_s2 <= result;
			wmod_s2   <= cfg.keep_result;
			wcomp_s2  <= cfg.keep_result && !animated_s1;
			last_s2   <= dest_s1.last;
		end
	end

	assign out_valid        = valid_s2;
	assign bank             = bank_s2;
	assign entry_index      = entry_s2;
	assign packed_result    = packed_s2;
	assign write_modified   = wmod_s2;
	assign write_components = wcomp_s2;
	assign last_entry       = last_s2;

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && dest.last |=> position == '0)
		else $error("position did not wrap after last entry");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(PosW+1)'(position) < (PosW+1)'(SECTION_ENTRIES))
		else $error("position beyond section");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> !in_stall)
		else $error("input stalled with free result stage");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_accept && load_s2 |=> !valid_s1)
		else $error("stage 1 transaction duplicated");

endmodule
